// ----- sv/ctgd_pkg.sv -----
// ctgd_pkg: shared types and constants for the crank tooth gap decoder.
// Used by ctgd_front, ctgd_queue, ctgd_back and crank_tooth_gap_decoder.
package ctgd_pkg;

    // Fixed field widths
    localparam int TIMER_BITS     = 16;
    localparam int COUNT_BITS     = 8;
    localparam int EFF_BITS       = 7;
    localparam int MASK_BITS      = 64;
    localparam int MASK_IDX_BITS  = 6;
    localparam int RPM_BITS       = 25;
    localparam int STEP_BITS      = 5;
    localparam int CFG_ADDR_BITS  = 5;
    localparam int CFG_DATA_BITS  = 64;

    // Highest tooth number that may raise an event
    localparam logic [COUNT_BITS-1:0] MAX_EVENT_TEETH = 8'd64;

    // RPM = RPM_NUMERATOR / tooth ticks
    localparam logic [RPM_BITS-1:0] RPM_NUMERATOR = 25'd26901000;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register reset values
    localparam logic [7:0]          GAP_SIZE_RST    = 8'd2;
    localparam logic [7:0]          TOOTH_TOTAL_RST = 8'd60;
    localparam logic [EFF_BITS-1:0] EFF_TEETH_RST   = 7'd58;

    // Input command codes; code 3 is unused
    typedef enum logic [1:0] {
        CMD_TOOTH = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_PHASE = 2'd2
    } t_cmd;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_GAP_SIZE    = 2'd0,
        REG_TOOTH_TOTAL = 2'd1,
        REG_EFF_TEETH   = 2'd2,
        REG_EVENT_MASK  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]           gap_size;
        logic [7:0]           tooth_total;
        logic [EFF_BITS-1:0]  effective_teeth;
        logic [MASK_BITS-1:0] event_mask;
    } t_cfg;

    // One classified word, handed from front to back
    typedef struct packed {
        logic                  tooth_event;
        logic [COUNT_BITS-1:0] tooth_number;
        logic                  phase_flag;
        logic                  phase_pin;
        logic [TIMER_BITS-1:0] tooth_ticks;
        logic [TIMER_BITS-1:0] gap_ticks;
        logic                  running;
    } t_rec;

    typedef enum logic {
        FR_IDLE = 1'b0,
        FR_MOD  = 1'b1
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_OUT  = 2'd2
    } t_back_state;

endpackage

// ----- sv/crank_tooth_gap_decoder.sv -----
// crank_tooth_gap_decoder: top level with the configuration registers.
// Instantiates ctgd_front, ctgd_queue and ctgd_back; depends on ctgd_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one event word: a tooth pulse
//   with its 16-bit timer capture, an engine-stopped timeout or a cam phase
//   edge. Output channel (o_valid / i_stall) returns one result word per
//   event: tooth event flag, tooth number, phase flag and pin, tooth and
//   gap ticks, running flag and RPM.
//   The front updates the wheel state in the accept cycle; when the count
//   must first be reduced modulo a lowered tooth total it first runs a
//   modulo pass. Records wait in a queue, so the front keeps taking words
//   while a result is held. The back divides 26901000 by the tooth ticks
//   with a one-bit-per-cycle divider, for a running word with nonzero
//   ticks only; it takes a new record only once the last result is taken.
//   Reset clears the wheel state and loads gap size 2, tooth total 60,
//   effective teeth 58 and an empty event mask. While the receiver stalls,
//   the result word holds, the queue fills and o_stall rises.
//   Registers are 64-bit at byte addresses 0, 8, 16, 24; write them only
//   while no word is in flight.
module crank_tooth_gap_decoder #(
    parameter int QUEUE_DEPTH = ctgd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_cmd,
    input  logic [15:0]                        i_capture_time,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_tooth_event,
    output logic [7:0]                         o_tooth_number,
    output logic                               o_phase_flag,
    output logic                               o_phase_pin,
    output logic [15:0]                        o_tooth_ticks,
    output logic [15:0]                        o_gap_ticks,
    output logic                               o_running,
    output logic [ctgd_pkg::RPM_BITS-1:0]      o_rpm,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ctgd_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [ctgd_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [ctgd_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import ctgd_pkg::*;

    logic [7:0]           r_gap_size;
    logic [7:0]           r_tooth_total;
    logic [EFF_BITS-1:0]  r_effective_teeth;
    logic [MASK_BITS-1:0] r_event_mask;

    t_cfg     w_cfg;
    t_reg_idx w_reg;
    logic     w_cfg_wr;
    logic     w_push, w_full, w_pop, w_empty;
    t_rec     w_front_rec, w_queue_rec;

    // Configuration port
    assign pready   = 1'b1;
    assign w_reg    = t_reg_idx'(paddr[4:3]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_size        <= GAP_SIZE_RST;
            r_tooth_total     <= TOOTH_TOTAL_RST;
            r_effective_teeth <= EFF_TEETH_RST;
            r_event_mask      <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_GAP_SIZE:    r_gap_size        <= pwdata[7:0];
                REG_TOOTH_TOTAL: r_tooth_total     <= pwdata[7:0];
                REG_EFF_TEETH:   r_effective_teeth <= pwdata[EFF_BITS-1:0];
                REG_EVENT_MASK:  r_event_mask      <= pwdata[MASK_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_reg)
            REG_GAP_SIZE:    prdata = {56'b0, r_gap_size};
            REG_TOOTH_TOTAL: prdata = {56'b0, r_tooth_total};
            REG_EFF_TEETH:   prdata = {57'b0, r_effective_teeth};
            REG_EVENT_MASK:  prdata = r_event_mask;
            default:         prdata = '0;
        endcase
    end

    assign w_cfg.gap_size        = r_gap_size;
    assign w_cfg.tooth_total     = r_tooth_total;
    assign w_cfg.effective_teeth = r_effective_teeth;
    assign w_cfg.event_mask      = r_event_mask;

    ctgd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_capture_time (i_capture_time),
        .i_cfg          (w_cfg),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_rec          (w_front_rec)
    );

    ctgd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_front_rec),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_rec   (w_queue_rec)
    );

    ctgd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_rec          (w_queue_rec),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_tooth_event  (o_tooth_event),
        .o_tooth_number (o_tooth_number),
        .o_phase_flag   (o_phase_flag),
        .o_phase_pin    (o_phase_pin),
        .o_tooth_ticks  (o_tooth_ticks),
        .o_gap_ticks    (o_gap_ticks),
        .o_running      (o_running),
        .o_rpm          (o_rpm)
    );

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("front pushed into a full queue");

    // A stopped engine reports zero RPM
    a_rpm_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_running) |-> (o_rpm == '0))
        else $error("nonzero rpm while stopped");

    // An event names a tooth inside the event range
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tooth_event) |->
        ((o_tooth_number != 8'd0) && (o_tooth_number <= MAX_EVENT_TEETH)))
        else $error("tooth event outside the event range");

endmodule

// ----- sv/ctgd_front.sv -----
// ctgd_front: accepts input words, updates the wheel state and pushes one
// record per word into the queue. Depends on ctgd_pkg.
module ctgd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_cmd,
    input  logic [15:0]      i_capture_time,
    input  ctgd_pkg::t_cfg   i_cfg,
    input  logic             i_full,
    output logic             o_push,
    output ctgd_pkg::t_rec   o_rec
);
    import ctgd_pkg::*;

    t_front_state r_state, n_state;

    logic [TIMER_BITS-1:0] r_last_capture, n_last_capture;
    logic [TIMER_BITS-1:0] r_last_interval, n_last_interval;
    logic                  r_have_capture, n_have_capture;
    logic [COUNT_BITS-1:0] r_tooth_count, n_tooth_count;
    logic [TIMER_BITS-1:0] r_tooth_interval, n_tooth_interval;
    logic [TIMER_BITS-1:0] r_gap_interval, n_gap_interval;
    logic                  r_phase_seen, n_phase_seen;
    logic                  r_phase_level, n_phase_level;

    logic [1:0]            r_cmd;
    logic [TIMER_BITS-1:0] r_cap;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic [2:0]            r_step;

    logic                  w_accept;
    logic                  w_need_mod;
    logic                  w_apply;
    logic [COUNT_BITS-1:0] w_total;
    logic [14:0]           w_sub;
    logic [14:0]           w_rem_ext;
    logic [14:0]           w_diff;
    logic [COUNT_BITS-1:0] w_count_mod;
    logic [1:0]            w_cmd;
    logic [TIMER_BITS-1:0] w_cap;
    logic [TIMER_BITS-1:0] w_delta;
    logic [COUNT_BITS-1:0] w_idx;
    logic                  w_ev;

    // Handshake: take a word only when idle and the queue has room
    assign o_stall  = (r_state != FR_IDLE) || i_full;
    assign w_accept = i_valid && !o_stall;
    assign w_total  = (i_cfg.tooth_total == 8'd0) ? 8'd1 : i_cfg.tooth_total;

    // With gap detection off, a tooth count above the tooth total needs a modulo pass first
    assign w_need_mod = (i_cmd == CMD_TOOTH) && r_have_capture &&
                        (i_cfg.gap_size == 8'd0) && (r_tooth_count > w_total);

    // One restoring step of count mod total per cycle
    assign w_sub     = {7'b0, w_total} << r_step;
    assign w_rem_ext = {7'b0, r_rem};
    assign w_diff    = w_rem_ext - w_sub;
    assign n_rem     = (w_rem_ext >= w_sub) ? w_diff[7:0] : r_rem;

    assign w_apply = ((r_state == FR_IDLE) && w_accept && !w_need_mod) ||
                     ((r_state == FR_MOD) && (r_step == 3'd0));

    // Pick the word and the reduced count for the update
    always_comb begin
        if (r_state == FR_IDLE) begin
            w_cmd       = i_cmd;
            w_cap       = i_capture_time;
            w_count_mod = (r_tooth_count == w_total) ? 8'd0 : r_tooth_count;
        end else begin
            w_cmd       = r_cmd;
            w_cap       = r_cap;
            w_count_mod = n_rem;
        end
    end

    assign w_delta = w_cap - r_last_capture;

    // Wheel state update for one word
    always_comb begin
        n_last_capture   = r_last_capture;
        n_last_interval  = r_last_interval;
        n_have_capture   = r_have_capture;
        n_tooth_count    = r_tooth_count;
        n_tooth_interval = r_tooth_interval;
        n_gap_interval   = r_gap_interval;
        n_phase_seen     = r_phase_seen;
        n_phase_level    = r_phase_level;
        case (w_cmd)
            CMD_TOOTH: begin
                if (r_have_capture) begin
                    if (i_cfg.gap_size != 8'd0) begin
                        if ({1'b0, w_delta} > {r_last_interval, 1'b0}) begin
                            n_gap_interval = w_delta;
                            n_tooth_count  = 8'd1;
                            n_phase_seen   = 1'b0;
                        end else begin
                            n_tooth_interval = w_delta;
                            if (r_tooth_count != 8'd0) begin
                                n_tooth_count = (r_tooth_count == 8'hFF) ? 8'd1 :
                                                r_tooth_count + 8'd1;
                            end
                        end
                    end else begin
                        n_tooth_interval = w_delta;
                        n_tooth_count    = w_count_mod + 8'd1;
                    end
                    n_last_interval = w_delta;
                end
                n_last_capture = w_cap;
                n_have_capture = 1'b1;
            end
            CMD_STOP: begin
                n_have_capture = 1'b0;
            end
            CMD_PHASE: begin
                n_phase_level = !r_phase_level;
                n_phase_seen  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Tooth event: counted tooth in range and enabled in the mask
    assign w_idx = n_tooth_count - 8'd1;
    assign w_ev  = (w_cmd == CMD_TOOTH) && r_have_capture &&
                   (n_tooth_count != 8'd0) &&
                   (n_tooth_count <= {1'b0, i_cfg.effective_teeth}) &&
                   (n_tooth_count <= MAX_EVENT_TEETH) &&
                   i_cfg.event_mask[w_idx[MASK_IDX_BITS-1:0]];

    // Build the record for the queue
    assign o_push             = w_apply;
    assign o_rec.tooth_event  = w_ev;
    assign o_rec.tooth_number = n_tooth_count;
    assign o_rec.phase_flag   = n_phase_seen;
    assign o_rec.phase_pin    = n_phase_level;
    assign o_rec.tooth_ticks  = n_tooth_interval;
    assign o_rec.gap_ticks    = n_gap_interval;
    assign o_rec.running      = n_have_capture;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_IDLE: begin
                if (w_accept && w_need_mod) begin
                    n_state = FR_MOD;
                end
            end
            FR_MOD: begin
                if (r_step == 3'd0) begin
                    n_state = FR_IDLE;
                end
            end
            default: n_state = FR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the wheel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_capture   <= '0;
            r_last_interval  <= '0;
            r_have_capture   <= 1'b0;
            r_tooth_count    <= '0;
            r_tooth_interval <= '0;
            r_gap_interval   <= '0;
            r_phase_seen     <= 1'b0;
            r_phase_level    <= 1'b0;
            r_step           <= '0;
        end else begin
            if (w_apply) begin
                r_last_capture   <= n_last_capture;
                r_last_interval  <= n_last_interval;
                r_have_capture   <= n_have_capture;
                r_tooth_count    <= n_tooth_count;
                r_tooth_interval <= n_tooth_interval;
                r_gap_interval   <= n_gap_interval;
                r_phase_seen     <= n_phase_seen;
                r_phase_level    <= n_phase_level;
            end
            if (r_state == FR_IDLE) begin
                r_step <= 3'd7;
            end else begin
                r_step <= r_step - 3'd1;
            end
        end
    end

    // Latch the word and advance the remainder during the modulo pass
    always_ff @(posedge i_clk) begin
        if (r_state == FR_IDLE) begin
            r_cmd <= i_cmd;
            r_cap <= i_capture_time;
            r_rem <= r_tooth_count;
        end else begin
            r_rem <= n_rem;
        end
    end

endmodule

// ----- sv/ctgd_queue.sv -----
// ctgd_queue: short first-in first-out queue of records between front and
// back. Depends on ctgd_pkg.
module ctgd_queue #(
    parameter int DEPTH = ctgd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ctgd_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ctgd_pkg::t_rec o_rec
);
    import ctgd_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    t_rec                r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                w_wr, w_rd;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd_ptr];

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- sv/ctgd_back.sv -----
// ctgd_back: pops records, computes RPM with a radix-2 restoring divider and
// holds the result word until the receiver takes it. Depends on ctgd_pkg.
module ctgd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  ctgd_pkg::t_rec                i_rec,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_tooth_event,
    output logic [7:0]                    o_tooth_number,
    output logic                          o_phase_flag,
    output logic                          o_phase_pin,
    output logic [15:0]                   o_tooth_ticks,
    output logic [15:0]                   o_gap_ticks,
    output logic                          o_running,
    output logic [ctgd_pkg::RPM_BITS-1:0] o_rpm
);
    import ctgd_pkg::*;

    t_back_state r_state, n_state;

    t_rec                  r_rec;
    logic [TIMER_BITS-1:0] r_rem, n_rem;
    logic [RPM_BITS-1:0]   r_quo, n_quo;
    logic [STEP_BITS-1:0]  r_step;
    logic                  w_do_div;
    logic [TIMER_BITS:0]   w_shift;
    logic [TIMER_BITS:0]   w_diff;
    logic                  w_qbit;

    assign o_pop    = (r_state == BK_IDLE) && !i_empty;
    assign w_do_div = i_rec.running && (i_rec.tooth_ticks != '0);

    // One quotient bit per cycle
    assign w_shift = {r_rem, r_quo[RPM_BITS-1]};
    assign w_diff  = w_shift - {1'b0, r_rec.tooth_ticks};
    assign w_qbit  = (w_shift >= {1'b0, r_rec.tooth_ticks});
    assign n_rem   = w_qbit ? w_diff[TIMER_BITS-1:0] : w_shift[TIMER_BITS-1:0];
    assign n_quo   = {r_quo[RPM_BITS-2:0], w_qbit};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = w_do_div ? BK_DIV : BK_OUT;
                end
            end
            BK_DIV: begin
                if (r_step == '0) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (!i_stall) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load the record, then iterate the divider
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_rec  <= i_rec;
                r_rem  <= '0;
                r_quo  <= w_do_div ? RPM_NUMERATOR : '0;
                r_step <= STEP_BITS'(RPM_BITS - 1);
            end
            BK_DIV: begin
                r_rem  <= n_rem;
                r_quo  <= n_quo;
                r_step <= r_step - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Drive the result word from the held record
    assign o_valid        = (r_state == BK_OUT);
    assign o_tooth_event  = r_rec.tooth_event;
    assign o_tooth_number = r_rec.tooth_number;
    assign o_phase_flag   = r_rec.phase_flag;
    assign o_phase_pin    = r_rec.phase_pin;
    assign o_tooth_ticks  = r_rec.tooth_ticks;
    assign o_gap_ticks    = r_rec.gap_ticks;
    assign o_running      = r_rec.running;
    assign o_rpm          = r_quo;

endmodule

// ----- sim/ctgd_wheel_checker.sv -----
`timescale 1ns / 100ps
// ctgd_wheel_checker: watches the event, result and register channels of the
// crank tooth gap decoder, predicts every result word and compares it.
// Depends on ctgd_pkg for command and register codes.
module ctgd_wheel_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [1:0]                         i_cmd,
    input  logic [15:0]                        i_capture_time,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic                               i_tooth_event,
    input  logic [7:0]                         i_tooth_number,
    input  logic                               i_phase_flag,
    input  logic                               i_phase_pin,
    input  logic [15:0]                        i_tooth_ticks,
    input  logic [15:0]                        i_gap_ticks,
    input  logic                               i_running,
    input  logic [ctgd_pkg::RPM_BITS-1:0]      i_rpm,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic                               i_pready,
    input  logic [ctgd_pkg::CFG_ADDR_BITS-1:0] i_paddr,
    input  logic [ctgd_pkg::CFG_DATA_BITS-1:0] i_pwdata,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import ctgd_pkg::*;

    localparam logic [31:0] RPM_DIVIDEND      = 32'd26901000;
    localparam int          EVENT_TEETH_LIMIT = 64;

    typedef struct packed {
        logic        tooth_event;
        logic [7:0]  tooth_number;
        logic        phase_flag;
        logic        phase_pin;
        logic [15:0] tooth_ticks;
        logic [15:0] gap_ticks;
        logic        running;
        logic [24:0] rpm;
    } t_wheel_word;

    // Register copies
    logic [7:0]  cfg_gap_size;
    logic [7:0]  cfg_tooth_total;
    logic [6:0]  cfg_eff_teeth;
    logic [63:0] cfg_event_mask;

    // Wheel state copies
    logic [15:0] prev_capture;
    logic [15:0] prev_interval;
    logic        capture_held;
    logic [7:0]  count;
    logic [15:0] tooth_iv;
    logic [15:0] gap_iv;
    logic        phase_seen_q;
    logic        phase_level_q;

    t_wheel_word expected_words[$];
    int          mismatch_total = 0;
    int          pending_words  = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = pending_words;

    // Advance the wheel state by one event word and return the result word
    function automatic t_wheel_word predict_wheel_word(input logic [1:0] cmd,
                                                       input logic [15:0] cap);
        t_wheel_word w;
        logic [15:0] delta;
        logic [7:0]  total;
        logic [31:0] quotient;
        logic        ev;
        ev = 1'b0;
        case (cmd)
            CMD_TOOTH: begin
                if (capture_held) begin
                    delta = cap - prev_capture;
                    if (cfg_gap_size != 8'd0) begin
                        // gap when the interval beats twice the previous one
                        if ({1'b0, delta} > {prev_interval, 1'b0}) begin
                            gap_iv       = delta;
                            count        = 8'd1;
                            phase_seen_q = 1'b0;
                        end else begin
                            tooth_iv = delta;
                            // hold zero until the first gap, wrap 255 to 1
                            if (count != 8'd0)
                                count = (count == 8'd255) ? 8'd1 : count + 8'd1;
                        end
                    end else begin
                        total    = (cfg_tooth_total == 8'd0) ? 8'd1 : cfg_tooth_total;
                        tooth_iv = delta;
                        count    = (count % total) + 8'd1;
                    end
                    if (count != 8'd0 && count <= {1'b0, cfg_eff_teeth}
                            && count <= EVENT_TEETH_LIMIT)
                        ev = cfg_event_mask[count - 8'd1];
                    prev_interval = delta;
                end
                prev_capture = cap;
                capture_held = 1'b1;
            end
            CMD_STOP: capture_held = 1'b0;
            CMD_PHASE: begin
                phase_level_q = ~phase_level_q;
                phase_seen_q  = 1'b1;
            end
            default: ;
        endcase
        quotient = 32'd0;
        if (capture_held && tooth_iv != 16'd0)
            quotient = RPM_DIVIDEND / {16'd0, tooth_iv};
        w.tooth_event  = ev;
        w.tooth_number = count;
        w.phase_flag   = phase_seen_q;
        w.phase_pin    = phase_level_q;
        w.tooth_ticks  = tooth_iv;
        w.gap_ticks    = gap_iv;
        w.running      = capture_held;
        w.rpm          = quotient[24:0];
        return w;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_wheel_word want;
        if (!i_rst_n) begin
            cfg_gap_size    = GAP_SIZE_RST;
            cfg_tooth_total = TOOTH_TOTAL_RST;
            cfg_eff_teeth   = EFF_TEETH_RST;
            cfg_event_mask  = '0;
            prev_capture    = '0;
            prev_interval   = '0;
            capture_held    = 1'b0;
            count           = '0;
            tooth_iv        = '0;
            gap_iv          = '0;
            phase_seen_q    = 1'b0;
            phase_level_q   = 1'b0;
            expected_words.delete();
        end else begin
            // Track register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:3])
                    REG_GAP_SIZE:    cfg_gap_size    = i_pwdata[7:0];
                    REG_TOOTH_TOTAL: cfg_tooth_total = i_pwdata[7:0];
                    REG_EFF_TEETH:   cfg_eff_teeth   = i_pwdata[6:0];
                    REG_EVENT_MASK:  cfg_event_mask  = i_pwdata;
                    default: ;
                endcase
            end
            // Compare an accepted result word with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("result word arrived with no prediction waiting");
                    mismatch_total++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("tooth_event", want.tooth_event, i_tooth_event);
                    check_field("tooth_number", want.tooth_number, i_tooth_number);
                    check_field("phase_flag", want.phase_flag, i_phase_flag);
                    check_field("phase_pin", want.phase_pin, i_phase_pin);
                    check_field("tooth_ticks", want.tooth_ticks, i_tooth_ticks);
                    check_field("gap_ticks", want.gap_ticks, i_gap_ticks);
                    check_field("running", want.running, i_running);
                    check_field("rpm", want.rpm, i_rpm);
                end
            end
            // Predict for an accepted event word
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(predict_wheel_word(i_cmd, i_capture_time));
        end
        pending_words = expected_words.size();
    end

endmodule

// ----- sim/tb_crank_tooth_gap_decoder.sv -----
`timescale 1ns / 100ps
// tb_crank_tooth_gap_decoder: drives event words and register writes into the
// crank tooth gap decoder and gives the verdict. Needs ctgd_pkg, the block
// and ctgd_wheel_checker.
module tb_crank_tooth_gap_decoder;
    import ctgd_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         IDLE_MAX       = 19;
    localparam int         RANDOM_PHASES  = 10;
    localparam int         LONG_RUN_PHASE = 4;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_valid        = 1'b0;
    logic                     o_stall;
    logic [1:0]               i_cmd          = 2'd0;
    logic [15:0]              i_capture_time = 16'd0;
    logic                     o_valid;
    logic                     i_stall        = 1'b0;
    logic                     o_tooth_event;
    logic [7:0]               o_tooth_number;
    logic                     o_phase_flag;
    logic                     o_phase_pin;
    logic [15:0]              o_tooth_ticks;
    logic [15:0]              o_gap_ticks;
    logic                     o_running;
    logic [RPM_BITS-1:0]      o_rpm;
    logic                     psel           = 1'b0;
    logic                     penable        = 1'b0;
    logic                     pwrite         = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr          = '0;
    logic [CFG_DATA_BITS-1:0] pwdata         = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    int   fail_count;
    int   pending;
    logic sender_idle      = 1'b1;
    logic sink_idle        = 1'b1;
    int   words_sent       = 0;
    int   settings_written = 0;

    crank_tooth_gap_decoder uut (.*);

    ctgd_wheel_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_cmd          (i_cmd),
        .i_capture_time (i_capture_time),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_tooth_event  (o_tooth_event),
        .i_tooth_number (o_tooth_number),
        .i_phase_flag   (o_phase_flag),
        .i_phase_pin    (o_phase_pin),
        .i_tooth_ticks  (o_tooth_ticks),
        .i_gap_ticks    (o_gap_ticks),
        .i_running      (o_running),
        .i_rpm          (o_rpm),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Offer one event word, after a random gap when sender_idle is set; return
    // at the falling edge after it is taken, with valid still high
    task automatic send_word(input logic [1:0] cmd, input logic [15:0] cap);
        int gap;
        gap = sender_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd          <= cmd;
        i_capture_time <= cap;
        i_valid        <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic hold_until_empty();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Setup and access cycle; psel stays high for a following write
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [7:0] gap, input logic [7:0] total,
                                  input logic [6:0] eff, input logic [63:0] mask);
        hold_until_empty();
        write_reg(REG_GAP_SIZE, {56'd0, gap});
        write_reg(REG_TOOTH_TOTAL, {56'd0, total});
        write_reg(REG_EFF_TEETH, {57'd0, eff});
        write_reg(REG_EVENT_MASK, mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_written++;
    endtask

    // Result sink: hold stall for a random count before each result word
    initial begin : result_sink
        int hold;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = sink_idle ? $urandom_range(0, IDLE_MAX) : 0;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int          ph, n, per_phase, roll, noise_pct;
        int          period, teeth_in_rev, teeth_left, missing;
        logic [31:0] step;
        logic [15:0] wheel_time;
        logic [1:0]  w_cmd;
        logic [15:0] w_cap;
        logic [7:0]  gap_pick, total_pick;
        logic [6:0]  eff_pick;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first capture, zero interval before any gap, gaps, wrap of
        // the timer, fastest tooth, stop and recapture, phase edges, unused code
        apply_settings(GAP_SIZE_RST, TOOTH_TOTAL_RST, EFF_TEETH_RST, '1);
        send_word(CMD_UNUSED, 16'hFFFF);
        send_word(CMD_TOOTH, 16'd5);
        send_word(CMD_TOOTH, 16'd5);
        send_word(CMD_TOOTH, 16'd105);
        send_word(CMD_TOOTH, 16'd205);
        send_word(CMD_PHASE, 16'h0000);
        send_word(CMD_TOOTH, 16'd305);
        send_word(CMD_TOOTH, 16'hFFF0);
        send_word(CMD_TOOTH, 16'h0050);
        send_word(CMD_TOOTH, 16'h0051);
        send_word(CMD_STOP, 16'hA5A5);
        send_word(CMD_PHASE, 16'h5A5A);
        send_word(CMD_PHASE, 16'hFFFF);
        send_word(CMD_TOOTH, 16'h1234);
        send_word(CMD_TOOTH, 16'h1235);
        send_word(CMD_UNUSED, 16'h0000);

        // No gap detection: cyclic count, then a lower total, then total zero
        apply_settings(8'd0, 8'd255, 7'd64, '1);
        send_word(CMD_TOOTH, 16'h123C);
        send_word(CMD_TOOTH, 16'h1243);
        send_word(CMD_TOOTH, 16'h124A);
        apply_settings(8'd0, 8'd3, 7'd2, 64'h0000_0000_0000_0002);
        send_word(CMD_TOOTH, 16'h1251);
        send_word(CMD_TOOTH, 16'h1258);
        send_word(CMD_TOOTH, 16'h125F);
        apply_settings(8'd0, 8'd0, 7'd1, 64'h0000_0000_0000_0001);
        send_word(CMD_TOOTH, 16'h1266);
        send_word(CMD_TOOTH, 16'h126D);

        // Random: a simulated wheel with steady teeth and gaps, plus noise
        wheel_time = 16'h1270;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: apply_settings(8'd2, 8'd60, 7'd58, {$urandom, $urandom});
                1: apply_settings(8'd0, 8'd255, 7'd64, '1);
                2: apply_settings(8'd255, 8'd1, 7'd0, '1);
                3: apply_settings(8'd1, 8'd0, 7'd64, 64'h8000_0000_0000_0001);
                LONG_RUN_PHASE: apply_settings(8'd2, 8'd60, 7'd64, '1);
                default: begin
                    gap_pick   = $urandom_range(0, 255);
                    if ($urandom_range(0, 3) == 0)
                        gap_pick = 8'd0;
                    total_pick = $urandom_range(1, 255);
                    eff_pick   = $urandom_range(0, 64);
                    apply_settings(gap_pick, total_pick, eff_pick, {$urandom, $urandom});
                end
            endcase

            sender_idle = ($urandom_range(0, 3) != 0);
            sink_idle   = ($urandom_range(0, 3) != 0);
            if (ph == LONG_RUN_PHASE) begin
                // one long revolution so the count wraps past 255
                period       = $urandom_range(16, 2000);
                teeth_in_rev = 300;
                missing      = 2;
                noise_pct    = 0;
                per_phase    = 340;
            end else begin
                period       = ($urandom_range(0, 5) == 0) ? $urandom_range(4000, 20000)
                                                           : $urandom_range(1, 4000);
                teeth_in_rev = $urandom_range(1, 70);
                missing      = $urandom_range(1, 4);
                noise_pct    = $urandom_range(5, 25);
                per_phase    = 100;
            end
            teeth_left = 0;

            for (n = 0; n < per_phase; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < noise_pct) begin
                    w_cmd = $urandom_range(0, 3);
                    w_cap = $urandom;
                end else if (roll < noise_pct + 4) begin
                    w_cmd = CMD_PHASE;
                    w_cap = $urandom;
                end else if (roll < noise_pct + 6) begin
                    w_cmd = CMD_STOP;
                    w_cap = $urandom;
                end else begin
                    // advance the wheel by a tooth, or by the gap at end of rev
                    if (teeth_left == 0) begin
                        step       = period * (missing + 1);
                        teeth_left = teeth_in_rev;
                    end else begin
                        step       = period + $urandom_range(0, period / 16);
                        teeth_left--;
                    end
                    wheel_time = wheel_time + step[15:0];
                    w_cmd      = CMD_TOOTH;
                    w_cap      = wheel_time;
                end
                send_word(w_cmd, w_cap);
            end
        end

        // Drain, then leave room for any stray result word
        hold_until_empty();
        repeat (60) @(negedge i_clk);
        $display("covered %0d event words over %0d register settings", words_sent,
                 settings_written);
        $display("wheel runs with gaps, long revolutions, stops, phase edges and noise");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #6_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
